@@ sv/homogeneous_matrix_transform_unit_defines.svh @@
// assertion macros for the homogeneous matrix transform unit
`ifndef HOMOGENEOUS_MATRIX_TRANSFORM_UNIT_DEFINES_SVH
`define HOMOGENEOUS_MATRIX_TRANSFORM_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define HMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HMT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define HMT_ASSERT(lbl, prop, msg)
`define HMT_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

@@ sv/hmt_pkg.sv @@
// shared types and constants of the homogeneous matrix transform unit
package hmt_pkg;

  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned ENTRY_W         = 32;
  localparam int unsigned FIELD_W         = 32;

  localparam logic [2:0] ACT_LOAD_FWD = 3'd0;
  localparam logic [2:0] ACT_LOAD_INV = 3'd1;
  localparam logic [2:0] ACT_POINT    = 3'd2;
  localparam logic [2:0] ACT_VECTOR   = 3'd3;
  localparam logic [2:0] ACT_NORMAL   = 3'd4;

  typedef struct packed {
    logic [2:0]                action;
    logic [3:0]                entry_index;
    logic signed [ENTRY_W-1:0] entry_value;
    logic signed [FIELD_W-1:0] in_x;
    logic signed [FIELD_W-1:0] in_y;
    logic signed [FIELD_W-1:0] in_z;
  } in_word_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_z;
    logic                      divide_fault;
  } out_word_t;

endpackage

@@ sv/homogeneous_matrix_transform_unit.sv @@
// homogeneous matrix transform unit: pipelined 4x4 fixed point transform with divider
// Takes one word per cycle unless the output stalls; each point, vector or normal
// result passes stages a to e, the divider stages and the output register. Load words
// update the forward or inverse matrix at once and give no result. The depth is set by
// the restoring divider for the point mode, which resolves one quotient bit per stage.
// A stall at the output holds the pipeline; the input stage still fills a free slot.
`include "homogeneous_matrix_transform_unit_defines.svh"

module homogeneous_matrix_transform_unit #(
  parameter int unsigned FRAC_BITS   = hmt_pkg::FRAC_BITS_DEF,
  parameter int unsigned COORD_WIDTH = hmt_pkg::COORD_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hmt_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hmt_pkg::out_word_t out_word_o
);

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned EW  = hmt_pkg::ENTRY_W;
  localparam int unsigned FW  = hmt_pkg::FIELD_W;
  localparam int unsigned PW  = EW + CW;
  localparam int unsigned XW  = (CW > F) ? CW : F + 1;
  localparam int unsigned SW  = EW + 2 + XW;
  localparam int unsigned NW  = SW + F;
  localparam int unsigned MW  = SW + ((F > CW) ? F : CW);
  localparam int unsigned NS  = CW + 7;
  localparam int unsigned OUT = NS - 1;

  localparam logic [EW-1:0]        ONE    = EW'(1) << F;
  localparam logic [CW-1:0]        MAXV   = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0]        MINV   = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [SW-1:0] SMAX   = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN   = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  logic [EW-1:0] fwd_q [16];
  logic [EW-1:0] inv_q [16];
  logic [NS-1:0] v_q;
  logic          en;
  logic          ld_a;
  logic          in_fire;
  logic          is_calc;

  // stage a
  logic                 a_pt_q;
  logic signed [EW-1:0] a_m_q [4][4];
  logic signed [CW-1:0] a_c_q [3];
  logic signed [EW-1:0] a_m_d [4][4];
  // stage b
  logic                 b_pt_q;
  logic signed [PW-1:0] b_p_q [4][3];
  logic signed [EW-1:0] b_t_q [4];
  // stage c
  logic                 c_pt_q;
  logic signed [SW-1:0] c_s0_q [4];
  logic signed [SW-1:0] c_s1_q [4];
  // stage d
  logic                 d_pt_q;
  logic signed [SW-1:0] d_sum_q [4];
  // stage e
  logic                 e_pt_q;
  logic [NW-1:0]        e_num_q [3];
  logic [SW-1:0]        e_den_q;
  logic [2:0]           e_neg_q, e_nz_q, e_sneg_q;
  logic                 e_wz_q;
  logic [CW-1:0]        e_res_q [3];
  logic [NW-1:0]        e_num_d [3];
  logic [SW-1:0]        e_den_d;
  logic [CW-1:0]        e_res_d [3];
  // divider stages
  logic [MW-1:0]        dv_rem_q [CW+1][3];
  logic [CW-1:0]        dv_quo_q [CW+1][3];
  logic [SW-1:0]        dv_den_q [CW+1];
  logic [2:0]           dv_ovf_q [CW+1];
  logic [2:0]           dv_neg_q [CW+1];
  logic [2:0]           dv_nz_q  [CW+1];
  logic [2:0]           dv_sneg_q [CW+1];
  logic                 dv_wz_q  [CW+1];
  logic                 dv_pt_q  [CW+1];
  logic [CW-1:0]        dv_res_q [CW+1][3];
  // output
  hmt_pkg::out_word_t   out_q, out_d;
  logic                 out_pt_q;
  logic [CW-1:0]        o_res [3];

  assign en          = !v_q[OUT] || out_ready_i;
  assign ld_a        = en || !v_q[0];
  assign in_ready_o  = ld_a;
  assign in_fire     = in_valid_i && in_ready_o;
  assign is_calc     = (in_word_i.action == hmt_pkg::ACT_POINT) ||
                       (in_word_i.action == hmt_pkg::ACT_VECTOR) ||
                       (in_word_i.action == hmt_pkg::ACT_NORMAL);
  assign out_valid_o = v_q[OUT];
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        fwd_q[i] <= (i % 5 == 0) ? ONE : '0;
        inv_q[i] <= (i % 5 == 0) ? ONE : '0;
      end
    end else if (in_fire) begin
      if (in_word_i.action == hmt_pkg::ACT_LOAD_FWD) begin
        fwd_q[in_word_i.entry_index] <= in_word_i.entry_value;
      end
      if (in_word_i.action == hmt_pkg::ACT_LOAD_INV) begin
        inv_q[in_word_i.entry_index] <= in_word_i.entry_value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld_a) begin
        v_q[0] <= in_fire && is_calc;
      end
      if (en) begin
        v_q[NS-1:1] <= v_q[NS-2:0];
      end
    end
  end

  // matrix selection per mode
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int k = 0; k < 4; k++) begin
        if (in_word_i.action == hmt_pkg::ACT_POINT) begin
          a_m_d[r][k] = fwd_q[r*4+k];
        end else if (r == 3 || k == 3) begin
          a_m_d[r][k] = '0;
        end else if (in_word_i.action == hmt_pkg::ACT_VECTOR) begin
          a_m_d[r][k] = fwd_q[r*4+k];
        end else begin
          a_m_d[r][k] = inv_q[k*4+r];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_a) begin
      a_pt_q   <= (in_word_i.action == hmt_pkg::ACT_POINT);
      a_m_q    <= a_m_d;
      a_c_q[0] <= CW'({{CW{1'b0}}, in_word_i.in_x});
      a_c_q[1] <= CW'({{CW{1'b0}}, in_word_i.in_y});
      a_c_q[2] <= CW'({{CW{1'b0}}, in_word_i.in_z});
    end
  end

  // magnitudes and shifted results for stage e
  always_comb begin
    logic signed [SW-1:0] sh;
    e_den_d = d_sum_q[3][SW-1] ? SW'(-d_sum_q[3]) : SW'(d_sum_q[3]);
    for (int r = 0; r < 3; r++) begin
      e_num_d[r] = NW'(d_sum_q[r][SW-1] ? SW'(-d_sum_q[r]) : SW'(d_sum_q[r])) << F;
      sh = d_sum_q[r] >>> F;
      if (sh > SMAX) begin
        e_res_d[r] = MAXV;
      end else if (sh < SMIN) begin
        e_res_d[r] = MINV;
      end else begin
        e_res_d[r] = sh[CW-1:0];
      end
    end
  end

  // final sign, saturation and zero w handling
  always_comb begin
    logic [CW-1:0] q;
    for (int r = 0; r < 3; r++) begin
      q = dv_quo_q[CW][r];
      if (!dv_pt_q[CW]) begin
        o_res[r] = dv_res_q[CW][r];
      end else if (dv_wz_q[CW]) begin
        o_res[r] = !dv_nz_q[CW][r] ? '0 : (dv_sneg_q[CW][r] ? MINV : MAXV);
      end else if (dv_ovf_q[CW][r]) begin
        o_res[r] = dv_neg_q[CW][r] ? MINV : MAXV;
      end else if (dv_neg_q[CW][r]) begin
        o_res[r] = (q > MINV) ? MINV : CW'(-q);
      end else begin
        o_res[r] = (q > MAXV) ? MAXV : q;
      end
    end
    out_d.out_x        = FW'({{FW{1'b0}}, o_res[0]});
    out_d.out_y        = FW'({{FW{1'b0}}, o_res[1]});
    out_d.out_z        = FW'({{FW{1'b0}}, o_res[2]});
    out_d.divide_fault = dv_pt_q[CW] && dv_wz_q[CW];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_pt_q <= a_pt_q;
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 3; k++) begin
          b_p_q[r][k] <= a_m_q[r][k] * a_c_q[k];
        end
        b_t_q[r] <= a_m_q[r][3];
      end

      c_pt_q <= b_pt_q;
      for (int r = 0; r < 4; r++) begin
        c_s0_q[r] <= SW'(b_p_q[r][0]) + SW'(b_p_q[r][1]);
        c_s1_q[r] <= SW'(b_p_q[r][2]) + (SW'(b_t_q[r]) <<< F);
      end

      d_pt_q <= c_pt_q;
      for (int r = 0; r < 4; r++) begin
        d_sum_q[r] <= c_s0_q[r] + c_s1_q[r];
      end

      e_pt_q  <= d_pt_q;
      e_num_q <= e_num_d;
      e_den_q <= e_den_d;
      e_res_q <= e_res_d;
      e_wz_q  <= (d_sum_q[3] == '0);
      for (int r = 0; r < 3; r++) begin
        e_neg_q[r]  <= d_sum_q[r][SW-1] ^ d_sum_q[3][SW-1];
        e_nz_q[r]   <= (d_sum_q[r] != '0);
        e_sneg_q[r] <= d_sum_q[r][SW-1];
      end

      // overflow check ahead of the bit steps
      dv_den_q[0]  <= e_den_q;
      dv_neg_q[0]  <= e_neg_q;
      dv_nz_q[0]   <= e_nz_q;
      dv_sneg_q[0] <= e_sneg_q;
      dv_wz_q[0]   <= e_wz_q;
      dv_pt_q[0]   <= e_pt_q;
      dv_res_q[0]  <= e_res_q;
      for (int r = 0; r < 3; r++) begin
        dv_rem_q[0][r] <= MW'(e_num_q[r]);
        dv_quo_q[0][r] <= '0;
        dv_ovf_q[0][r] <= MW'(e_num_q[r]) >= (MW'(e_den_q) << CW);
      end

      // one quotient bit per stage
      for (int s = 1; s <= CW; s++) begin
        dv_den_q[s]  <= dv_den_q[s-1];
        dv_neg_q[s]  <= dv_neg_q[s-1];
        dv_nz_q[s]   <= dv_nz_q[s-1];
        dv_sneg_q[s] <= dv_sneg_q[s-1];
        dv_wz_q[s]   <= dv_wz_q[s-1];
        dv_pt_q[s]   <= dv_pt_q[s-1];
        dv_res_q[s]  <= dv_res_q[s-1];
        dv_ovf_q[s]  <= dv_ovf_q[s-1];
        for (int r = 0; r < 3; r++) begin
          if (dv_rem_q[s-1][r] >= (MW'(dv_den_q[s-1]) << (CW - s))) begin
            dv_rem_q[s][r] <= dv_rem_q[s-1][r] - (MW'(dv_den_q[s-1]) << (CW - s));
            dv_quo_q[s][r] <= dv_quo_q[s-1][r] | (CW'(1) << (CW - s));
          end else begin
            dv_rem_q[s][r] <= dv_rem_q[s-1][r];
            dv_quo_q[s][r] <= dv_quo_q[s-1][r];
          end
        end
      end

      out_q    <= out_d;
      out_pt_q <= dv_pt_q[CW];
    end
  end

  `HMT_ASSERT(a_load_no_result, in_fire && !is_calc |=> !v_q[0], "load word entered pipe")
  `HMT_ASSERT(a_stall_holds, !en |=> $stable(v_q[NS-1:1]), "pipe moved during stall")
  `HMT_ASSERT_IMP(a_fault_point, out_valid_o && out_word_o.divide_fault, out_pt_q,
                  "fault on non point")
  `HMT_ASSERT_IMP(a_ready_low, !in_ready_o, out_valid_o && !out_ready_i && v_q[0], "bad ready")
  `HMT_ASSERT(a_fwd_write,
              in_fire && in_word_i.action == hmt_pkg::ACT_LOAD_FWD |=>
              fwd_q[$past(in_word_i.entry_index)] == $past(in_word_i.entry_value),
              "fwd write lost")

endmodule

@@ dv/homogeneous_matrix_transform_unit_checker.sv @@
// checker for the homogeneous matrix transform unit: predicts each result word and compares
`timescale 1ns / 100ps

module homogeneous_matrix_transform_unit_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  hmt_pkg::in_word_t  in_word_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  hmt_pkg::out_word_t out_word_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int unsigned FB = hmt_pkg::FRAC_BITS_DEF;

  logic signed [31:0] fwd_mat [16];
  logic signed [31:0] inv_mat [16];
  hmt_pkg::out_word_t expected_words [$];

  function automatic logic signed [31:0] clamp_coord(logic signed [127:0] v);
    logic signed [127:0] hi_lim;
    logic signed [127:0] lo_lim;
    hi_lim = 128'sh7FFF_FFFF;
    lo_lim = -128'sh8000_0000;
    if (v > hi_lim) return 32'sh7FFF_FFFF;
    if (v < lo_lim) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] widen(logic signed [31:0] v);
    logic signed [127:0] w;
    w = v;
    return w;
  endfunction

  function automatic hmt_pkg::out_word_t transform_word(hmt_pkg::in_word_t w);
    hmt_pkg::out_word_t  r;
    logic signed [127:0] c [3];
    logic signed [127:0] acc [4];
    logic signed [127:0] m;
    logic signed [31:0]  o [3];
    c[0] = widen(w.in_x);
    c[1] = widen(w.in_y);
    c[2] = widen(w.in_z);
    r.divide_fault = 1'b0;
    if (w.action == hmt_pkg::ACT_POINT) begin
      for (int i = 0; i < 4; i++) begin
        acc[i] = widen(fwd_mat[i*4+3]) <<< FB;
        for (int k = 0; k < 3; k++) begin
          m = widen(fwd_mat[i*4+k]);
          acc[i] = acc[i] + m * c[k];
        end
      end
      if (acc[3] == 0) begin
        r.divide_fault = 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (acc[i] == 0) o[i] = '0;
          else if (acc[i] < 0) o[i] = 32'sh8000_0000;
          else o[i] = 32'sh7FFF_FFFF;
        end
      end else begin
        for (int i = 0; i < 3; i++) o[i] = clamp_coord((acc[i] <<< FB) / acc[3]);
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        acc[i] = '0;
        for (int k = 0; k < 3; k++) begin
          m = (w.action == hmt_pkg::ACT_VECTOR) ? widen(fwd_mat[i*4+k])
                                                : widen(inv_mat[k*4+i]);
          acc[i] = acc[i] + m * c[k];
        end
        o[i] = clamp_coord(acc[i] >>> FB);
      end
    end
    r.out_x = o[0];
    r.out_y = o[1];
    r.out_z = o[2];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hmt_pkg::out_word_t want;
    if (!rst_ni) begin
      fail_count_o = 0;
      expected_words.delete();
      for (int i = 0; i < 16; i++) begin
        fwd_mat[i] = (i % 5 == 0) ? 32'sh0001_0000 : '0;
        inv_mat[i] = (i % 5 == 0) ? 32'sh0001_0000 : '0;
      end
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", out_word_i[31:0], '0);
        end else begin
          want = expected_words.pop_front();
          if (out_word_i.out_x !== want.out_x)
            report_mismatch("out_x", out_word_i.out_x, want.out_x);
          if (out_word_i.out_y !== want.out_y)
            report_mismatch("out_y", out_word_i.out_y, want.out_y);
          if (out_word_i.out_z !== want.out_z)
            report_mismatch("out_z", out_word_i.out_z, want.out_z);
          if (out_word_i.divide_fault !== want.divide_fault)
            report_mismatch("divide_fault", 32'(out_word_i.divide_fault),
                            32'(want.divide_fault));
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (in_word_i.action) inside
          hmt_pkg::ACT_LOAD_FWD: fwd_mat[in_word_i.entry_index] = in_word_i.entry_value;
          hmt_pkg::ACT_LOAD_INV: inv_mat[in_word_i.entry_index] = in_word_i.entry_value;
          hmt_pkg::ACT_POINT, hmt_pkg::ACT_VECTOR, hmt_pkg::ACT_NORMAL:
            expected_words.push_back(transform_word(in_word_i));
          default: ;
        endcase
      end
    end
    pending_o = expected_words.size();
  end

endmodule

@@ dv/homogeneous_matrix_transform_unit_tb.sv @@
// testbench top for the homogeneous matrix transform unit: stimulus, idling and verdict
`timescale 1ns / 100ps

module homogeneous_matrix_transform_unit_tb;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_ready;
  hmt_pkg::in_word_t  in_word;
  logic               out_valid;
  logic               out_ready;
  hmt_pkg::out_word_t out_word;
  int                 fail_count;
  int                 pending;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  longint             cycle_count;

  homogeneous_matrix_transform_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  homogeneous_matrix_transform_unit_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_word_i   (out_word),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > 3_000_000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  always @(posedge clk_i) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  function automatic logic [31:0] rand_value();
    if ($urandom_range(9) < 6) return 32'($signed($urandom_range(16 << 16)) - (8 << 16));
    return $urandom;
  endfunction

  function automatic hmt_pkg::in_word_t make_word(logic [2:0] act, logic [3:0] idx,
                                                  logic [31:0] val, logic [31:0] x,
                                                  logic [31:0] y, logic [31:0] z);
    hmt_pkg::in_word_t w;
    w.action = act;
    w.entry_index = idx;
    w.entry_value = val;
    w.in_x = x;
    w.in_y = y;
    w.in_z = z;
    return w;
  endfunction

  // called just after a rising edge; returns just after the accepting edge
  task automatic send_word(hmt_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word <= w;
    forever begin
      @(negedge clk_i);
      if (in_ready) break;
    end
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic send_random_word();
    logic [2:0] act;
    logic [3:0] idx;
    logic [31:0] val;
    act = 3'($urandom_range(99) < 20 ? $urandom_range(1) : $urandom_range(4, 2));
    if ($urandom_range(99) < 2) act = 3'($urandom_range(7, 5));
    idx = 4'($urandom);
    val = rand_value();
    if (idx >= 12 && $urandom_range(99) < 30) val = '0;
    send_word(make_word(act, idx, val, rand_value(), rand_value(), rand_value()));
  endtask

  initial begin
    logic [31:0] big;
    logic [31:0] neg;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    big = 32'h7FFF_FFFF;
    neg = 32'h8000_0000;
    send_word(make_word(hmt_pkg::ACT_POINT, '0, '0, 32'h0001_0000, 32'hFFFE_0000,
                        32'h0003_8000));
    send_word(make_word(hmt_pkg::ACT_VECTOR, '0, '0, big, neg, '0));
    send_word(make_word(hmt_pkg::ACT_NORMAL, '0, '0, neg, big, 32'hFFFF_FFFF));
    send_word(make_word(hmt_pkg::ACT_LOAD_FWD, 4'd0, big, '0, '0, '0));
    send_word(make_word(hmt_pkg::ACT_LOAD_FWD, 4'd5, neg, '0, '0, '0));
    send_word(make_word(hmt_pkg::ACT_LOAD_FWD, 4'd3, 32'h0002_0000, '0, '0, '0));
    send_word(make_word(hmt_pkg::ACT_VECTOR, '0, '0, big, big, neg));
    send_word(make_word(hmt_pkg::ACT_POINT, '0, '0, big, neg, 32'h0000_0001));
    send_word(make_word(hmt_pkg::ACT_LOAD_INV, 4'd15, neg, '0, '0, '0));
    send_word(make_word(hmt_pkg::ACT_LOAD_INV, 4'd1, big, '0, '0, '0));
    send_word(make_word(hmt_pkg::ACT_NORMAL, '0, '0, big, neg, big));
    send_word(make_word(hmt_pkg::ACT_LOAD_FWD, 4'd15, '0, '0, '0, '0));
    send_word(make_word(hmt_pkg::ACT_POINT, '0, '0, 32'h0001_0000, '0, '0));
    send_word(make_word(hmt_pkg::ACT_POINT, '0, '0, '0, '0, '0));
    send_word(make_word(hmt_pkg::ACT_LOAD_FWD, 4'd12, 32'h0000_0001, '0, '0, '0));
    send_word(make_word(hmt_pkg::ACT_POINT, '0, '0, 32'h0000_0001, neg, '0));
    send_word(make_word(hmt_pkg::ACT_POINT, '0, '0, '0, 32'h0000_0001, '0));
    send_word(make_word(3'd5, 4'hF, big, big, big, big));
    send_word(make_word(3'd6, 4'h0, neg, neg, neg, neg));
    send_word(make_word(3'd7, 4'h7, '0, '0, '0, '0));
    send_word(make_word(hmt_pkg::ACT_VECTOR, '0, '0, 32'h0001_0000, 32'h0001_0000,
                        32'h0001_0000));
    drain_results();

    send_idle_pct = 28;
    recv_idle_pct = 72;
    repeat (580) send_random_word();
    drain_results();
    send_idle_pct = 72;
    recv_idle_pct = 28;
    repeat (580) send_random_word();
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (580) send_random_word();
    drain_results();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
